// File: hdl/gbio_pkg.sv
package gbio_pkg;

    // usable pixels per row, counted from bit 63 downward
    localparam int ROW_BITS = 64;
    localparam logic [63:0] ROW_MASK = {64{1'b1}} << (64 - ROW_BITS);
    localparam logic [63:0] ROW_LSB  = 64'd1 << (64 - ROW_BITS);
    localparam logic [6:0]  ROW_BITS_W = 7'(ROW_BITS);

    // configuration register indexes
    localparam logic [2:0] CFG_GLYPH_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_GLYPH_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_BOLD_ENABLE    = 3'd2;
    localparam logic [2:0] CFG_ITALIC_ENABLE  = 3'd3;
    localparam logic [2:0] CFG_OUTLINE_ENABLE = 3'd4;

    typedef logic [63:0] t_row;

    typedef struct packed {
        logic [6:0] glyph_width;
        logic [7:0] glyph_height;
        logic       bold_enable;
        logic       italic_enable;
        logic       outline_enable;
    } t_cfg;

    // everything one source row produces
    typedef struct packed {
        t_row [2:0] rows;
        logic [1:0] count;
        logic [6:0] width;
        logic       last;
        logic       lost;
        t_row       styled;
    } t_style;

endpackage

// File: hdl/gbio_style.sv
module gbio_style (
    input  gbio_pkg::t_cfg   i_cfg,
    input  gbio_pkg::t_row   i_row_pixels,
    input  logic [7:0]       i_row_count,
    input  gbio_pkg::t_row   i_prev,
    input  gbio_pkg::t_row   i_prev2,
    output gbio_pkg::t_style o_style
);

    logic [6:0]     w;
    logic [7:0]     h;
    logic [5:0]     sh;
    logic           last;
    logic           lost;
    logic [7:0]     width_sum;
    logic [7:0]     outline_w;
    gbio_pkg::t_row px;
    gbio_pkg::t_row sx;

    // off pixels with a set pixel to the left or right
    function automatic gbio_pkg::t_row horiz(input gbio_pkg::t_row v);
        return ((v << 1) | (v >> 1)) & ~v & gbio_pkg::ROW_MASK;
    endfunction

    always_comb begin
        w  = (i_cfg.glyph_width > 7'd64) ? 7'd64 : i_cfg.glyph_width;
        h  = (i_cfg.glyph_height == 8'd0) ? 8'd1 : i_cfg.glyph_height;
        last = (({1'b0, i_row_count} + 9'd1) >= {1'b0, h});
        sh = (i_row_count < h) ? 6'((h - i_row_count) >> 2) : 6'd0;

        px = (w == 7'd0) ? '0 : (i_row_pixels & ({64{1'b1}} << (7'd64 - w)));
        lost = 1'b0;
        width_sum = {1'b0, w};

        if (i_cfg.bold_enable) begin
            lost = lost | px[0];
            px = px | (px >> 1);
            width_sum = width_sum + 8'd1;
        end
        if (i_cfg.italic_enable) begin
            lost = lost | (|(px & ~({64{1'b1}} << sh)));
            px = px >> sh;
            width_sum = width_sum + {2'b00, h[7:2]};
        end

        // stored row is the styled row padded one pixel on the left
        lost = lost | px[0] | (|((px >> 1) & ~gbio_pkg::ROW_MASK));
        sx = (px >> 1) & gbio_pkg::ROW_MASK;
        outline_w = width_sum + 8'd2;

        o_style = '0;
        o_style.last   = last;
        o_style.styled = sx;

        if (!i_cfg.outline_enable) begin
            lost = lost | (|(px & ~gbio_pkg::ROW_MASK));
            o_style.rows[0] = px & gbio_pkg::ROW_MASK;
            o_style.count   = 2'd1;
            o_style.width   = (width_sum > {1'b0, gbio_pkg::ROW_BITS_W}) ?
                              gbio_pkg::ROW_BITS_W : width_sum[6:0];
        end else begin
            lost = lost | (|(sx & gbio_pkg::ROW_LSB));
            o_style.rows[0] = (horiz(i_prev) | (sx & ~i_prev) | (i_prev2 & ~i_prev))
                              & gbio_pkg::ROW_MASK;
            o_style.rows[1] = (horiz(sx) | (i_prev & ~sx)) & gbio_pkg::ROW_MASK;
            o_style.rows[2] = sx & gbio_pkg::ROW_MASK;
            o_style.count   = last ? 2'd3 : 2'd1;
            o_style.width   = (outline_w > {1'b0, gbio_pkg::ROW_BITS_W}) ?
                              gbio_pkg::ROW_BITS_W : outline_w[6:0];
        end
        o_style.lost = lost;
    end

endmodule

// File: hdl/glyph_bold_italic_outline_top.sv
// Synthetic bold, oblique and outline for 1-bit glyphs, one source row per input beat
// (bit 63 is the leftmost pixel). A row is captured in an input register, styled in one
// pass of shift-and-mask logic and written to a result holder, so a result beat is always
// offered from the holder; a new row is taken every cycle while the holder can take it. Each
// row gives one result beat, except the final row of a glyph in outline mode, which gives
// three; the holder drains one beat per cycle while i_out_ready is high, and the next row
// waits for them to drain. Configuration writes take effect at once, are always accepted
// and should be made only while idle.
module glyph_bold_italic_outline_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_row_pixels,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_pixels,
    output logic [6:0]  o_out_width,
    output logic [8:0]  o_row_index,
    output logic        o_last_row,
    output logic        o_clipped
);

    gbio_pkg::t_cfg   r_cfg;
    gbio_pkg::t_style style;

    logic           r_in_valid;
    gbio_pkg::t_row r_in_pixels;

    logic [7:0]     r_row_count;
    gbio_pkg::t_row r_prev;
    gbio_pkg::t_row r_prev2;

    gbio_pkg::t_row [2:0] r_rows;
    logic [1:0]     r_rem;
    logic [6:0]     r_width;
    logic [8:0]     r_y;
    logic           r_last;
    logic           r_lost;

    logic drain;
    logic hold_free;
    logic advance;

    assign o_cfg_ready = 1'b1;

    assign o_out_valid = (r_rem != 2'd0);
    assign drain       = o_out_valid && i_out_ready;
    assign hold_free   = (r_rem == 2'd0) || ((r_rem == 2'd1) && i_out_ready);
    assign advance     = r_in_valid && hold_free;
    assign o_in_ready  = !r_in_valid || advance;

    assign o_out_pixels = r_rows[0];
    assign o_out_width  = r_width;
    assign o_row_index  = r_y;
    assign o_last_row   = r_last && (r_rem == 2'd1);
    assign o_clipped    = r_lost;

    gbio_style u_style (
        .i_cfg        (r_cfg),
        .i_row_pixels (r_in_pixels),
        .i_row_count  (r_row_count),
        .i_prev       (r_prev),
        .i_prev2      (r_prev2),
        .o_style      (style)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_width    <= 7'd8;
            r_cfg.glyph_height   <= 8'd16;
            r_cfg.bold_enable    <= 1'b0;
            r_cfg.italic_enable  <= 1'b0;
            r_cfg.outline_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gbio_pkg::CFG_GLYPH_WIDTH:    r_cfg.glyph_width    <= i_cfg_data[6:0];
                gbio_pkg::CFG_GLYPH_HEIGHT:   r_cfg.glyph_height   <= i_cfg_data;
                gbio_pkg::CFG_BOLD_ENABLE:    r_cfg.bold_enable    <= i_cfg_data[0];
                gbio_pkg::CFG_ITALIC_ENABLE:  r_cfg.italic_enable  <= i_cfg_data[0];
                gbio_pkg::CFG_OUTLINE_ENABLE: r_cfg.outline_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_rem       <= 2'd0;
            r_row_count <= 8'd0;
            r_prev      <= '0;
            r_prev2     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_rem <= style.count;
                if (style.last) begin
                    r_row_count <= 8'd0;
                    r_prev      <= '0;
                    r_prev2     <= '0;
                end else begin
                    r_row_count <= r_row_count + 8'd1;
                    r_prev2     <= r_prev;
                    r_prev      <= style.styled;
                end
            end else if (drain) begin
                r_rem <= r_rem - 2'd1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_pixels <= i_row_pixels;
        end
        if (advance) begin
            r_rows  <= style.rows;
            r_width <= style.width;
            r_y     <= {1'b0, r_row_count};
            r_last  <= style.last;
            r_lost  <= style.lost;
        end else if (drain) begin
            // next beat of the same source row moves to the front
            r_rows[0] <= r_rows[1];
            r_rows[1] <= r_rows[2];
            r_y       <= r_y + 9'd1;
        end
    end

endmodule

// File: tb/glyph_bold_italic_outline_top_tb.sv
`timescale 1ns / 100ps

module glyph_bold_italic_outline_top_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic [63:0] pixels;
        logic [6:0]  width;
        logic [8:0]  index;
        logic        last;
        logic        clipped;
    } t_out_beat;

    class glyph_row_checker;
        logic [6:0]  glyph_width;
        logic [7:0]  glyph_height;
        bit          bold_on;
        bit          italic_on;
        bit          outline_on;
        logic [7:0]  row_count;
        logic [63:0] prev_row;
        logic [63:0] prev2_row;
        bit          step_lost;
        t_out_beat   styled_beats_q[$];
        int          rows_taken;
        int          beats_seen;
        int          errors;

        function new();
            glyph_width  = 7'd8;
            glyph_height = 8'd16;
            bold_on      = 0;
            italic_on    = 0;
            outline_on   = 0;
            row_count    = '0;
            prev_row     = '0;
            prev2_row    = '0;
            rows_taken   = 0;
            beats_seen   = 0;
            errors       = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] data);
            case (idx)
                gbio_pkg::CFG_GLYPH_WIDTH:    glyph_width  = data[6:0];
                gbio_pkg::CFG_GLYPH_HEIGHT:   glyph_height = data;
                gbio_pkg::CFG_BOLD_ENABLE:    bold_on      = data[0];
                gbio_pkg::CFG_ITALIC_ENABLE:  italic_on    = data[0];
                gbio_pkg::CFG_OUTLINE_ENABLE: outline_on   = data[0];
                default: ;
            endcase
        endfunction

        // pixels shifted out past bit 0 count as lost
        function logic [63:0] shr_lossy(logic [63:0] v, int unsigned amt);
            if (amt == 0) return v;
            if (amt >= 64) begin
                if (v != 0) step_lost = 1;
                return '0;
            end
            if ((v & ((64'd1 << amt) - 64'd1)) != 0) step_lost = 1;
            return v >> amt;
        endfunction

        function logic [63:0] side_marks(logic [63:0] v);
            return (((v << 1) | (v >> 1)) & ~v) & gbio_pkg::ROW_MASK;
        endfunction

        function logic [6:0] cap_width(int unsigned x);
            return 7'((x > gbio_pkg::ROW_BITS) ? gbio_pkg::ROW_BITS : x);
        endfunction

        function void push_beat(logic [63:0] px, logic [6:0] w, int unsigned idx, bit lst);
            t_out_beat b;
            b.pixels  = px & gbio_pkg::ROW_MASK;
            b.width   = w;
            b.index   = 9'(idx);
            b.last    = lst;
            b.clipped = step_lost;
            styled_beats_q.push_back(b);
        endfunction

        function void take_source_row(logic [63:0] px);
            int unsigned w, h, y, sh, width;
            bit          lst;
            logic [63:0] r, s;
            w = (glyph_width > 64) ? 64 : glyph_width;
            h = (glyph_height == 0) ? 1 : glyph_height;
            y = row_count;
            lst = (y + 1 >= h);
            step_lost = 0;
            rows_taken++;

            r = (w == 0) ? 64'd0 : (px & (~64'd0 << (64 - w)));
            width = w;
            if (bold_on) begin
                r = r | shr_lossy(r, 1);
                width++;
            end
            if (italic_on) begin
                // rows past the configured height get no shear
                sh = (y < h) ? ((h - y) >> 2) : 0;
                r = shr_lossy(r, sh);
                width += h >> 2;
            end
            // outline works on the row padded one pixel on the left
            s = shr_lossy(r, 1);
            if ((s & ~gbio_pkg::ROW_MASK) != 0) step_lost = 1;
            s &= gbio_pkg::ROW_MASK;

            if (!outline_on) begin
                if ((r & ~gbio_pkg::ROW_MASK) != 0) step_lost = 1;
                push_beat(r, cap_width(width), y, lst);
            end else begin
                if ((s & gbio_pkg::ROW_LSB) != 0) step_lost = 1;
                push_beat(side_marks(prev_row) | (s & ~prev_row) | (prev2_row & ~prev_row),
                          cap_width(width + 2), y, 1'b0);
                if (lst) begin
                    push_beat(side_marks(s) | (prev_row & ~s), cap_width(width + 2), y + 1,
                              1'b0);
                    push_beat(s, cap_width(width + 2), y + 2, 1'b1);
                end
            end

            if (lst) begin
                row_count = '0;
                prev_row  = '0;
                prev2_row = '0;
            end else begin
                row_count = row_count + 8'd1;
                prev2_row = prev_row;
                prev_row  = s;
            end
        endfunction

        function void field_check(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
            end
        endfunction

        function void check_out_beat(logic [63:0] px, logic [6:0] w, logic [8:0] idx,
                                     logic lst, logic clp);
            t_out_beat b;
            beats_seen++;
            if (styled_beats_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, got pixels %h index %0d",
                         $time, px, idx);
                return;
            end
            b = styled_beats_q.pop_front();
            field_check("out_pixels", b.pixels, px);
            field_check("out_width", 64'(b.width), 64'(w));
            field_check("row_index", 64'(b.index), 64'(idx));
            field_check("last_row", 64'(b.last), 64'(lst));
            field_check("clipped", 64'(b.clipped), 64'(clp));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_row_pixels;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_out_pixels;
    logic [6:0]  o_out_width;
    logic [8:0]  o_row_index;
    logic        o_last_row;
    logic        o_clipped;

    glyph_row_checker sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles = 0;
    int hold_left = 0;
    int style_count;
    bit hold_req;

    glyph_bold_italic_outline_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_row_pixels (i_row_pixels),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_pixels (o_out_pixels),
        .o_out_width  (o_out_width),
        .o_row_index  (o_row_index),
        .o_last_row   (o_last_row),
        .o_clipped    (o_clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: ready pattern, hold-off, checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_out_beat(o_out_pixels, o_out_width, o_row_index, o_last_row, o_clipped);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
        if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [63:0] rand_row();
        logic [63:0] v;
        int          sel;
        sel = $urandom_range(4);
        case (sel)
            0: v = '1;
            1: v = 64'd1 << $urandom_range(63);
            2: v = {$urandom, $urandom} & {$urandom, $urandom};
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic wait_drained();
        while (sb.styled_beats_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // all registers are rewritten, only once the block has gone quiet
    task automatic set_style(input logic [7:0] w, input logic [7:0] h,
                             input bit b, input bit it, input bit ol);
        i_in_valid <= 1'b0;
        wait_drained();
        write_reg(gbio_pkg::CFG_GLYPH_WIDTH, w);
        write_reg(gbio_pkg::CFG_GLYPH_HEIGHT, h);
        write_reg(gbio_pkg::CFG_BOLD_ENABLE, {7'd0, b});
        write_reg(gbio_pkg::CFG_ITALIC_ENABLE, {7'd0, it});
        write_reg(gbio_pkg::CFG_OUTLINE_ENABLE, {7'd0, ol});
        i_cfg_valid <= 1'b0;
        style_count++;
    endtask

    task automatic send_row(input logic [63:0] px);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_row_pixels <= px;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_source_row(px);
    endtask

    task automatic run_random(input int rows_goal);
        int          sent;
        int          n;
        int          k;
        int          wsel;
        int          hsel;
        logic [7:0]  w;
        logic [7:0]  h;
        int unsigned h_eff;
        sent = 0;
        while (sent < rows_goal) begin
            wsel = $urandom_range(9);
            if (wsel == 0)      w = 8'd64;
            else if (wsel == 1) w = 8'($urandom_range(65, 255));
            else if (wsel == 2) w = 8'd0;
            else                w = 8'($urandom_range(1, 63));
            hsel = $urandom_range(9);
            if (hsel == 0)      h = 8'd0;
            else if (hsel == 1) h = 8'($urandom_range(9, 24));
            else                h = 8'($urandom_range(1, 6));
            set_style(w, h, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
            h_eff = (h == 0) ? 1 : h;
            // mostly whole glyphs, now and then a glyph cut short by the next setting
            if ($urandom_range(3) == 0) n = $urandom_range(1, h_eff);
            else                        n = h_eff * $urandom_range(1, 2);
            for (k = 0; k < n; k++) send_row(rand_row());
            sent += n;
        end
    endtask

    initial begin
        int k;
        sb = new();
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = gbio_pkg::CFG_GLYPH_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_row_pixels  = '0;
        hold_req      = 0;
        style_count   = 0;
        send_idle_pct = 23;
        recv_idle_pct = 84;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain rows, single-row glyphs, edge pixels
        set_style(8'd64, 8'd1, 0, 0, 0);
        send_row('1);
        send_row('0);
        send_row(64'h8000_0000_0000_0000);
        send_row(64'h0000_0000_0000_0001);
        // bold outline on a full row loses the rightmost pixels
        set_style(8'd64, 8'd1, 1, 0, 1);
        send_row('1);
        send_row(64'hAAAA_AAAA_AAAA_AAAA);
        // zero width with zero height
        set_style(8'd0, 8'd0, 1, 1, 0);
        send_row('1);
        // width beyond 64, tallest glyph, then height lowered mid glyph
        set_style(8'hFF, 8'd255, 0, 1, 1);
        send_row('1);
        send_row(64'h5555_5555_5555_5555);
        send_row(64'hF000_0000_0000_000F);
        set_style(8'hFF, 8'd2, 0, 1, 1);
        send_row(64'hC000_0000_0000_0003);
        // narrowest glyph with every style on
        set_style(8'd1, 8'd4, 1, 1, 1);
        for (k = 0; k < 4; k++) send_row((k % 2 == 0) ? 64'h8000_0000_0000_0000 : rand_row());
        // bits beyond the width are ignored
        set_style(8'd5, 8'd3, 0, 0, 0);
        for (k = 0; k < 3; k++) send_row(~64'd0 >> k);

        run_random(50);
        send_idle_pct = 84;
        recv_idle_pct = 23;
        run_random(50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(34);

        // receiver stalls while rows keep coming, so the input backs up
        set_style(8'd16, 8'd8, 1, 0, 1);
        hold_req = 1;
        for (k = 0; k < 16; k++) send_row(rand_row());

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d source rows over %0d style settings, %0d result beats compared",
                 sb.rows_taken, style_count, sb.beats_seen);
        $display("mismatches: %0d", sb.errors);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: glyph_bold_italic_outline_top.f
hdl/gbio_pkg.sv
hdl/gbio_style.sv
hdl/glyph_bold_italic_outline_top.sv
tb/glyph_bold_italic_outline_top_tb.sv
